>>> rtl/bvwm_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor package
// Shared widths, constants, register indexes and the configuration type.
// ----------------------------------------------------------------------------
package bvwm_pkg;

  localparam int unsigned AdcW   = 12;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned CvW    = 12;
  localparam int unsigned DvW    = 9;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // Half of 7260 * adc + 806715, floored: 3630 * adc + 403357.
  localparam logic [AdcW-1:0]  ScaleMulHalf = 12'd3630;
  localparam logic [HalfW-1:0] ScaleAddHalf = 24'd403357;

  // Reciprocal of 4095 scaled by 2^36, exact for every reachable operand.
  localparam logic [24:0] ScaleRecip  = 25'd16781314;
  localparam int unsigned ScaleShift  = 36;

  // 52429 / 2^18 is one fifth, 52429 / 2^19 is one tenth, exact in range.
  localparam logic [15:0] RecipFive   = 16'd52429;
  localparam int unsigned FiveShift   = 18;
  localparam int unsigned TenShift    = 19;

  localparam logic [DvW-1:0]  WinLowRst  = 9'd180;
  localparam logic [DvW-1:0]  WinHighRst = 9'd310;
  localparam logic [CntW-1:0] ReloadRst  = 8'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWinLow  = 2'd0,
    CfgWinHigh = 2'd1,
    CfgReload  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DvW-1:0]  win_low;
    logic [DvW-1:0]  win_high;
    logic [CntW-1:0] reload;
  } cfg_t;

endpackage

>>> rtl/bvwm_scale.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor sample scaling
// Two registered stages turn a converter reading into centivolts.
// ----------------------------------------------------------------------------
module bvwm_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bvwm_pkg::AdcW-1:0] adc_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bvwm_pkg::CvW-1:0]  scaled_o
);
  import bvwm_pkg::*;

  logic             half_vld_q;
  logic [HalfW-1:0] half_d, half_q;
  logic             scl_vld_q;
  logic [CvW-1:0]   scl_d, scl_q;
  logic [48:0]      prod;
  logic             rdy1, rdy2;

  assign rdy2 = !scl_vld_q || out_ready_i;
  assign rdy1 = !half_vld_q || rdy2;

  assign half_d = HalfW'(adc_i) * HalfW'(ScaleMulHalf) + ScaleAddHalf;
  assign prod   = 49'(half_q) * 49'(ScaleRecip);
  assign scl_d  = prod[ScaleShift +: CvW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_vld_q <= 1'b0;
      scl_vld_q  <= 1'b0;
    end else begin
      if (rdy1) half_vld_q <= in_valid_i;
      if (rdy2) scl_vld_q  <= half_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) half_q <= half_d;
    if (rdy2 && half_vld_q) scl_q  <= scl_d;
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = scl_vld_q;
  assign scaled_o    = scl_q;

endmodule

>>> rtl/bvwm_filter.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor smoothing filter
// First-order filter stage followed by a decivolt conversion stage.
// ----------------------------------------------------------------------------
module bvwm_filter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [bvwm_pkg::CvW-1:0] scaled_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [bvwm_pkg::CvW-1:0] filt_o,
  output logic [bvwm_pkg::DvW-1:0] level_o
);
  import bvwm_pkg::*;

  logic           flt_vld_q;
  logic [CvW-1:0] flt_d, flt_q;
  logic           lvl_vld_q;
  logic [CvW-1:0] cv_q;
  logic [DvW-1:0] lvl_d, lvl_q;
  logic [14:0]    sum;
  logic [30:0]    prod5;
  logic [27:0]    prod10;
  logic           rdy1, rdy2;

  assign rdy2 = !lvl_vld_q || out_ready_i;
  assign rdy1 = !flt_vld_q || rdy2;

  assign sum    = {1'b0, flt_q, 2'b00} + 15'(scaled_i);
  assign prod5  = 31'(sum) * 31'(RecipFive);
  assign flt_d  = prod5[FiveShift +: CvW];
  assign prod10 = 28'(flt_q) * 28'(RecipFive);
  assign lvl_d  = prod10[TenShift +: DvW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flt_vld_q <= 1'b0;
      lvl_vld_q <= 1'b0;
      flt_q     <= '0;
    end else begin
      if (rdy1) flt_vld_q <= in_valid_i;
      if (rdy2) lvl_vld_q <= flt_vld_q;
      if (rdy1 && in_valid_i) flt_q <= flt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && flt_vld_q) begin
      cv_q  <= flt_q;
      lvl_q <= lvl_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = lvl_vld_q;
  assign filt_o      = cv_q;
  assign level_o     = lvl_q;

endmodule

>>> rtl/bvwm_window.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor window check
// Compares the level with the window, runs the debounce counter and holds
// the result register.
// ----------------------------------------------------------------------------
module bvwm_window (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bvwm_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [bvwm_pkg::CvW-1:0] filt_i,
  input  logic [bvwm_pkg::DvW-1:0] level_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [bvwm_pkg::CvW-1:0] filt_o,
  output logic [bvwm_pkg::DvW-1:0] level_o,
  output logic                     normal_o,
  output logic                     low_o,
  output logic                     high_o
);
  import bvwm_pkg::*;

  logic            vld_q;
  logic            rdy;
  logic            load;
  logic            in_win;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            normal_d, normal_q;
  logic            low_d, low_q;
  logic            high_d, high_q;
  logic [CvW-1:0]  cv_q;
  logic [DvW-1:0]  lvl_q;

  assign rdy    = !vld_q || out_ready_i;
  assign load   = rdy && in_valid_i;
  assign in_win = (level_i >= cfg_i.win_low) && (level_i <= cfg_i.win_high);

  always_comb begin
    cnt_d    = cnt_q;
    normal_d = normal_q;
    low_d    = low_q;
    high_d   = high_q;
    if (in_win) begin
      normal_d = 1'b1;
      low_d    = 1'b0;
      high_d   = 1'b0;
      cnt_d    = cfg_i.reload;
    end else begin
      normal_d = 1'b0;
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CntW'(1);
      end else if (level_i < cfg_i.win_low) begin
        low_d  = 1'b1;
        high_d = 1'b0;
      end else begin
        high_d = 1'b1;
        low_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      cnt_q    <= ReloadRst;
      normal_q <= 1'b0;
      low_q    <= 1'b0;
      high_q   <= 1'b0;
    end else begin
      if (rdy) vld_q <= in_valid_i;
      if (load) begin
        cnt_q    <= cnt_d;
        normal_q <= normal_d;
        low_q    <= low_d;
        high_q   <= high_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cv_q  <= filt_i;
      lvl_q <= level_i;
    end
  end

  assign in_ready_o  = rdy;
  assign out_valid_o = vld_q;
  assign filt_o      = cv_q;
  assign level_o     = lvl_q;
  assign normal_o    = normal_q;
  assign low_o       = low_q;
  assign high_o      = high_q;

endmodule

>>> rtl/battery_voltage_window_monitor_top.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor
// An input transfer reaches the result on the master side through two scaling
// stages, the filter stage, the decivolt stage and the window result register.
// One sample per cycle is taken in steady state when the master side is ready.
// Reset clears the filter and flags and loads the window and debounce
// registers with their defaults; the debounce counter starts at 200.
// ----------------------------------------------------------------------------
module battery_voltage_window_monitor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // adc_sample, zero fill
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // filtered_cv, level_dv, power_normal, power_low, power_high
  output logic [23:0]                  m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [bvwm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bvwm_pkg::DvW-1:0]     cfg_data_i
);
  import bvwm_pkg::*;

  cfg_t           cfg_q;
  logic           scl_vld, scl_rdy;
  logic [CvW-1:0] scl;
  logic           flt_vld, flt_rdy;
  logic [CvW-1:0] flt_cv;
  logic [DvW-1:0] flt_lvl;
  logic [CvW-1:0] out_cv;
  logic [DvW-1:0] out_lvl;
  logic           out_normal, out_low, out_high;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_low  <= WinLowRst;
      cfg_q.win_high <= WinHighRst;
      cfg_q.reload   <= ReloadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgWinLow:  cfg_q.win_low  <= cfg_data_i;
        CfgWinHigh: cfg_q.win_high <= cfg_data_i;
        CfgReload:  cfg_q.reload   <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  bvwm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .adc_i       (s_axis_tdata[AdcW-1:0]),
    .out_valid_o (scl_vld),
    .out_ready_i (scl_rdy),
    .scaled_o    (scl)
  );

  bvwm_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scl_vld),
    .in_ready_o  (scl_rdy),
    .scaled_i    (scl),
    .out_valid_o (flt_vld),
    .out_ready_i (flt_rdy),
    .filt_o      (flt_cv),
    .level_o     (flt_lvl)
  );

  bvwm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (flt_vld),
    .in_ready_o  (flt_rdy),
    .filt_i      (flt_cv),
    .level_i     (flt_lvl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .filt_o      (out_cv),
    .level_o     (out_lvl),
    .normal_o    (out_normal),
    .low_o       (out_low),
    .high_o      (out_high)
  );

  assign m_axis_tdata = {out_high, out_low, out_normal, out_lvl, out_cv};

  a_low_high_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_low && out_high))
    else $error("low and high flags set together");

  a_normal_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_normal |-> (!out_low && !out_high))
    else $error("normal flag set with low or high flag");

  a_level_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_lvl <= 9'(out_cv >> 3)))
    else $error("level does not follow filtered value");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery voltage window monitor testbench
// Streams converter samples into the monitor and checks every result transfer
// against an in-bench model of the scaling, the smoothing filter, the window
// compare and the debounce logic. Directed tests cover the field extremes,
// zero debounce, an inverted window and an ignored register index. Random
// phases run under several window settings with sample runs aimed at the
// window edges. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import bvwm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned LatencyCycles = 5;

  typedef struct packed {
    logic            over_flag;
    logic            under_flag;
    logic            power_normal;
    logic [DvW-1:0]  level_dv;
    logic [CvW-1:0]  filtered_cv;
  } monitor_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DvW-1:0]     cfg_data_i = '0;

  logic [DvW-1:0]  win_low_dv;
  logic [DvW-1:0]  win_high_dv;
  logic [CntW-1:0] reload_count;
  logic [CvW-1:0]  filter_cv;
  logic [CntW-1:0] debounce_left;
  logic            low_seen;
  logic            high_seen;
  logic            normal_seen;

  monitor_result_t expected_results[$];
  int unsigned     error_count = 0;
  bit              quiet_mode = 1'b0;

  battery_voltage_window_monitor_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic monitor_result_t predict_monitor(input logic [AdcW-1:0] adc);
    int unsigned     scaled;
    int unsigned     smoothed;
    logic [DvW-1:0]  level;
    monitor_result_t res;
    scaled = (32'd7260 * {20'd0, adc} + 32'd806715) / 32'd8190;
    smoothed = (32'd4 * {20'd0, filter_cv} + scaled) / 32'd5;
    filter_cv = smoothed[CvW-1:0];
    level = DvW'(filter_cv / 12'd10);
    if (level >= win_low_dv && level <= win_high_dv) begin
      normal_seen = 1'b1;
      low_seen = 1'b0;
      high_seen = 1'b0;
      debounce_left = reload_count;
    end else begin
      normal_seen = 1'b0;
      if (debounce_left > 0) begin
        debounce_left = debounce_left - CntW'(1);
      end else if (level < win_low_dv) begin
        low_seen = 1'b1;
        high_seen = 1'b0;
      end else if (level > win_high_dv) begin
        high_seen = 1'b1;
        low_seen = 1'b0;
      end
    end
    res.filtered_cv = filter_cv;
    res.level_dv = level;
    res.power_normal = normal_seen;
    res.under_flag = low_seen;
    res.over_flag = high_seen;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AdcW-1:0] adc_clamp(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[AdcW-1:0];
  endfunction

  // Converter reading whose scaled value lands near the given decivolt level.
  function automatic logic [AdcW-1:0] adc_for_level(input int level);
    return adc_clamp((level * 81900 - 806715) / 7260);
  endfunction

  task automatic send_sample(input logic [AdcW-1:0] adc);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, adc};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_monitor(adc));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DvW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgWinLow: begin
        win_low_dv = value;
      end
      CfgWinHigh: begin
        win_high_dv = value;
      end
      CfgReload: begin
        reload_count = value[CntW-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_window(input int lo, input int hi, input int reload);
    wait_idle();
    write_reg(CfgWinLow, DvW'(lo));
    write_reg(CfgWinHigh, DvW'(hi));
    write_reg(CfgReload, DvW'(reload));
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  initial begin : result_checker
    monitor_result_t exp_r;
    monitor_result_t act_r;
    int unsigned     stall_left;
    int unsigned     r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        act_r = monitor_result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("filtered_cv", 16'(exp_r.filtered_cv), 16'(act_r.filtered_cv));
          check_field("level_dv", 16'(exp_r.level_dv), 16'(act_r.level_dv));
          check_field("power_normal", 16'(exp_r.power_normal), 16'(act_r.power_normal));
          check_field("under_flag", 16'(exp_r.under_flag), 16'(act_r.under_flag));
          check_field("over_flag", 16'(exp_r.over_flag), 16'(act_r.over_flag));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd0);
  endtask

  task automatic test_zero_reload_swing();
    set_window(180, 310, 0);
    repeat (12) send_sample(12'd4095);
    repeat (6) send_sample(12'd0);
  endtask

  task automatic test_inverted_window();
    set_window(300, 100, 1);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd0);
  endtask

  task automatic test_ignored_index();
    wait_idle();
    write_reg(CfgUnused, 9'h1FF);
    write_reg(CfgReload, 9'h1FF);
    send_sample(12'hAAA);
    send_sample(12'h555);
  endtask

  task automatic run_phase(input int lo, input int hi, input int reload,
                           input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int          target;
    int          center;
    logic [AdcW-1:0] adc;
    set_window(lo, hi, reload);
    sent = 0;
    while (sent < count) begin
      quiet_mode = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 2))
          0: target = lo;
          1: target = hi;
          default: target = int'($urandom_range(0, 400));
        endcase
        target = target + int'($urandom_range(0, 12)) - 6;
        center = int'(adc_for_level(target));
        len = $urandom_range(1, 40);
        repeat (len) begin
          if ($urandom_range(0, 19) == 0) adc = AdcW'($urandom_range(0, 4095));
          else adc = adc_clamp(center + int'($urandom_range(0, 40)) - 20);
          send_sample(adc);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          send_sample(AdcW'($urandom_range(0, 4095)));
          sent++;
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_settings();
    run_phase(180, 310, 200, 150);
    run_phase(90, 160, $urandom_range(0, 15), 250);
    run_phase(0, 0, 0, 150);
    run_phase(400, 400, 255, 150);
    run_phase(400, 0, 3, 150);
    run_phase(0, 400, $urandom_range(0, 255), 100);
    repeat (2) begin
      run_phase($urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 31), 150);
    end
  endtask

  initial begin
    win_low_dv = WinLowRst;
    win_high_dv = WinHighRst;
    reload_count = ReloadRst;
    filter_cv = '0;
    debounce_left = ReloadRst;
    low_seen = 1'b0;
    high_seen = 1'b0;
    normal_seen = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_zero_reload_swing();
    test_inverted_window();
    test_ignored_index();
    test_random_settings();
    wait_idle();
    repeat (4 * LatencyCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
